>>> src/bracket_balance_checker_unit_assert.svh
// Assertion macros for the checker file.
// Expects clk and arst_n in the scope of use.
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bbc_pkg.sv
// Package for the bracket balance checker: types, character and status codes.
// No dependencies.
`default_nettype none
package bbc_pkg;

	localparam int BBC_STACK_DEPTH = 64;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NONE    = 2'd0;
	localparam kind_t KIND_PAREN   = 2'd1;
	localparam kind_t KIND_BRACKET = 2'd2;
	localparam kind_t KIND_CURLY   = 2'd3;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef logic [3:0] status_t;
	localparam status_t ST_OK            = 4'd0;
	localparam status_t ST_MISMATCH_BASE = 4'd0;
	localparam status_t ST_TOO_MANY_BASE = 4'd3;
	localparam status_t ST_UNCLOSED_BASE = 4'd6;
	localparam status_t ST_UNCLOSED_PAR  = 4'd7;
	localparam status_t ST_UNCLOSED_BRK  = 4'd8;
	localparam status_t ST_UNCLOSED_CRL  = 4'd9;
	localparam status_t ST_OVERFLOW      = 4'd10;

	typedef struct packed {
		status_t status;
		logic    line_done;
	} res_t;

	function automatic kind_t open_kind_of(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_LPAREN: k = KIND_PAREN;
			CH_LBRACK: k = KIND_BRACKET;
			CH_LBRACE: k = KIND_CURLY;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t close_kind_of(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_RPAREN: k = KIND_PAREN;
			CH_RBRACK: k = KIND_BRACKET;
			CH_RBRACE: k = KIND_CURLY;
			default:   k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic status_t code_of(input status_t base, input kind_t k);
		return base + {2'b00, k};
	endfunction

endpackage
`default_nettype wire

>>> src/bracket_balance_checker_unit.sv
// Top level of the bracket balance checker: stack control and counters.
// Uses bbc_pkg, bbc_stack_mem, bbc_out_buf.
//
//  channel | signals                         | dir | word
//  src     | src_valid, src_stall, ch, line_end | in  | one character
//  res     | res_valid, res_stall, status, line_done | out | one verdict
//
// One character per cycle unless src_stall; results are registered.
// Top of stack sits in a register; the entry below it is prefetched from
// the stack memory, so a pop finds the new top without waiting.
// Reset clears level, counters and held error; the memory needs no clearing.
// src_stall rises only when both output register and skid stage hold words.
`default_nettype none
module bracket_balance_checker_unit #(
	parameter int STACK_DEPTH = bbc_pkg::BBC_STACK_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] ch,
	input  wire logic       line_end,
	output logic            res_valid,
	input  wire logic       res_stall,
	output bbc_pkg::status_t status,
	output logic            line_done
);
	import bbc_pkg::*;

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [LW-1:0] level_q, level_d, level_n;
	logic [LW-1:0] cnt_par_q, cnt_brk_q, cnt_crl_q;
	logic [LW-1:0] cnt_par_d, cnt_brk_d, cnt_crl_d;
	kind_t         top_q, top_d, below;
	status_t       held_q, held_d, verdict;
	kind_t         ok, ck;
	logic          acc, push_w;
	logic [LW-1:0] raddr_w;
	logic          buf_full;
	res_t          new_res, out_res;

	assign acc = src_valid && !buf_full;
	assign src_stall = buf_full;
	assign ok = open_kind_of(ch);
	assign ck = close_kind_of(ch);

	always_comb begin
		level_d   = level_q;
		top_d     = top_q;
		held_d    = held_q;
		cnt_par_d = cnt_par_q;
		cnt_brk_d = cnt_brk_q;
		cnt_crl_d = cnt_crl_q;
		push_w    = 1'b0;
		if (held_q == ST_OK) begin
			if (ok != KIND_NONE) begin
				if (level_q == LW'(STACK_DEPTH)) begin
					held_d = ST_OVERFLOW;
				end else begin
					push_w  = 1'b1;
					level_d = level_q + LW'(1);
					top_d   = ok;
					case (ok)
						KIND_PAREN:   cnt_par_d = cnt_par_q + LW'(1);
						KIND_BRACKET: cnt_brk_d = cnt_brk_q + LW'(1);
						default:      cnt_crl_d = cnt_crl_q + LW'(1);
					endcase
				end
			end else if (ck != KIND_NONE) begin
				if (level_q == '0) begin
					held_d = code_of(ST_TOO_MANY_BASE, ck);
				end else if (top_q != ck) begin
					held_d = code_of(ST_MISMATCH_BASE, ck);
				end else begin
					level_d = level_q - LW'(1);
					top_d   = below;
					case (ck)
						KIND_PAREN:   cnt_par_d = cnt_par_q - LW'(1);
						KIND_BRACKET: cnt_brk_d = cnt_brk_q - LW'(1);
						default:      cnt_crl_d = cnt_crl_q - LW'(1);
					endcase
				end
			end
		end
		verdict = held_d;
		if (line_end && held_d == ST_OK) begin
			if (cnt_par_d != '0) begin
				verdict = ST_UNCLOSED_PAR;
			end else if (cnt_brk_d != '0) begin
				verdict = ST_UNCLOSED_BRK;
			end else if (cnt_crl_d != '0) begin
				verdict = ST_UNCLOSED_CRL;
			end
		end
		if (line_end) begin
			level_d   = '0;
			held_d    = ST_OK;
			cnt_par_d = '0;
			cnt_brk_d = '0;
			cnt_crl_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			held_q    <= ST_OK;
			cnt_par_q <= '0;
			cnt_brk_q <= '0;
			cnt_crl_q <= '0;
		end else if (acc) begin
			level_q   <= level_d;
			held_q    <= held_d;
			cnt_par_q <= cnt_par_d;
			cnt_brk_q <= cnt_brk_d;
			cnt_crl_q <= cnt_crl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			top_q <= top_d;
		end
	end

	// prefetch the entry under the next top
	assign level_n = acc ? level_d : level_q;
	assign raddr_w = level_n - LW'(2);

	bbc_stack_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (acc && push_w),
		.waddr(level_q[AW-1:0]),
		.wdata(ok),
		.raddr(raddr_w[AW-1:0]),
		.rdata(below)
	);

	assign new_res.status    = verdict;
	assign new_res.line_done = line_end;

	bbc_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.push_res (new_res),
		.full     (buf_full),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (out_res)
	);

	assign status    = out_res.status;
	assign line_done = out_res.line_done;

endmodule
`default_nettype wire

>>> src/bbc_stack_mem.sv
// Kind stack storage: one write port, one registered read port.
// Uses bbc_pkg.
`default_nettype none
module bbc_stack_mem #(
	parameter int DEPTH = bbc_pkg::BBC_STACK_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire bbc_pkg::kind_t  wdata,
	input  wire logic [AW-1:0]   raddr,
	output bbc_pkg::kind_t       rdata
);
	import bbc_pkg::*;

	kind_t mem [DEPTH];
	kind_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> src/bbc_out_buf.sv
// Output register with skid stage for result words.
// Uses bbc_pkg.
`default_nettype none
module bbc_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bbc_pkg::res_t push_res,
	output logic               full,
	output logic               res_valid,
	input  wire logic          res_stall,
	output bbc_pkg::res_t      res
);
	import bbc_pkg::*;

	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !res_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !res_stall) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign full      = skid_v_q;
	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule
`default_nettype wire

>>> src/bbc_checker.sv
// Port-level checks for bracket_balance_checker_unit, attached by bind.
// Uses bbc_pkg and bracket_balance_checker_unit_assert.svh.
`default_nettype none
`include "bracket_balance_checker_unit_assert.svh"
module bbc_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             src_stall,
	input wire logic             res_valid,
	input wire logic             res_stall,
	input wire bbc_pkg::status_t status,
	input wire logic             line_done
);
	import bbc_pkg::*;

	`BBC_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid, "result word dropped")
	`BBC_ASSERT_NXT(a_res_stable, res_valid && res_stall, $stable(status) && $stable(line_done), "stalled word changed")
	`BBC_ASSERT_IMP(a_stall_full, src_stall, res_valid, "input stalled with empty output")
	`BBC_ASSERT_IMP(a_midline, res_valid && !line_done, status != ST_UNCLOSED_PAR && status != ST_UNCLOSED_BRK && status != ST_UNCLOSED_CRL, "unclosed verdict mid-line")
	`BBC_ASSERT_IMP(a_range, res_valid, status <= ST_OVERFLOW, "status out of range")

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.src_stall(src_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.status   (status),
	.line_done(line_done)
);
`default_nettype wire
